### rtl/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gwm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int CHAR_BITS   = 16;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int VEC_W = PATTERN_MAX + 1;

   localparam logic [CHAR_BITS-1:0] UNIT_STAR = CHAR_BITS'(42);
   localparam logic [CHAR_BITS-1:0] UNIT_ANY  = CHAR_BITS'(63);

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_EMPTY   = 2'd1,
      OP_SUBJECT = 2'd2,
      OP_END     = 2'd3
   } op_type;

endpackage
`default_nettype wire

### rtl/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Glob matcher: load a pattern unit by unit ('*' any run, '?' one unit), then stream
// subject units; the final subject unit, or an end-empty-subject beat, returns one
// match bit. One beat is taken every clock, unless a result-bearing beat waits while
// rsp_stall holds the last result; input register, then result register. The per-unit
// work is one parallel compare over all pattern positions and one carry-chain add that
// spreads live positions through runs of stars, all between those two registers.
module glob_wildcard_matcher (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [1:0]                        req_operation,
   input  wire  [gwm_pkg::CHAR_BITS-1:0]     req_symbol,
   input  wire                               req_last,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_matched
);

   logic                              s1_valid_ff, s1_valid_in;
   gwm_pkg::op_type                   s1_op_ff;
   logic [gwm_pkg::CHAR_BITS-1:0]     s1_sym_ff;
   logic                              s1_last_ff;

   logic [gwm_pkg::CHAR_BITS-1:0]     units_ff [gwm_pkg::PATTERN_MAX];
   logic                              unit_we;
   logic [gwm_pkg::IDX_W-1:0]         unit_idx;

   logic [gwm_pkg::LEN_W-1:0]         len_ff, len_in;
   logic                              open_ff, open_in;
   logic                              busy_ff, busy_in;
   logic [gwm_pkg::VEC_W-1:0]         live_ff, live_in;
   logic [gwm_pkg::VEC_W-1:0]         start_ff, start_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_matched_ff, rsp_matched_in;

   logic                              req_accept;
   logic                              s1_has_result;
   logic                              s1_block;
   logic                              s1_fire;

   logic [gwm_pkg::VEC_W-1:0]         star_vec;
   logic [gwm_pkg::VEC_W-1:0]         base_vec;
   logic [gwm_pkg::VEC_W-1:0]         adv_vec;
   logic [gwm_pkg::VEC_W-1:0]         seed_vec;
   logic [gwm_pkg::VEC_W-1:0]         sum_vec;
   logic [gwm_pkg::VEC_W-1:0]         closed_vec;
   logic [gwm_pkg::PATTERN_MAX-1:0]   hit_vec;
   logic [gwm_pkg::LEN_W-1:0]         wr_pos;
   logic [gwm_pkg::LEN_W-1:0]         wr_next;
   logic                              sym_star;

   assign s1_has_result = (s1_op_ff == gwm_pkg::OP_END) ||
                          ((s1_op_ff == gwm_pkg::OP_SUBJECT) && s1_last_ff);
   assign s1_block      = s1_has_result && rsp_valid_ff && rsp_stall;
   assign s1_fire       = s1_valid_ff && !s1_block;
   assign req_stall     = s1_valid_ff && s1_block;
   assign req_accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= gwm_pkg::op_type'(req_operation);
         s1_sym_ff  <= req_symbol;
         s1_last_ff <= req_last;
      end
   end

   always_comb begin
      star_vec = '0;
      hit_vec  = '0;
      for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
         star_vec[i] = (gwm_pkg::LEN_W'(i) < len_ff) && (units_ff[i] == gwm_pkg::UNIT_STAR);
         hit_vec[i]  = (gwm_pkg::LEN_W'(i) < len_ff) &&
                       ((units_ff[i] == gwm_pkg::UNIT_ANY) || (units_ff[i] == s1_sym_ff));
      end
   end

   assign base_vec = busy_ff ? live_ff : start_ff;

   always_comb begin
      adv_vec = '0;
      for (int i = 1; i < gwm_pkg::VEC_W; i++) begin
         if (star_vec[i-1]) begin
            adv_vec[i] = base_vec[i] || base_vec[i-1];
         end else begin
            adv_vec[i] = base_vec[i-1] && hit_vec[i-1];
         end
      end
   end

   // spread live bits through runs of stars with one carry chain
   assign seed_vec   = adv_vec & star_vec;
   assign sum_vec    = star_vec + seed_vec;
   assign closed_vec = adv_vec | (sum_vec ^ star_vec ^ seed_vec);

   assign wr_pos   = open_ff ? len_ff : '0;
   assign wr_next  = wr_pos + gwm_pkg::LEN_W'(1);
   assign unit_idx = wr_pos[gwm_pkg::IDX_W-1:0];
   assign sym_star = (s1_sym_ff == gwm_pkg::UNIT_STAR);

   always_comb begin
      len_in         = len_ff;
      open_in        = open_ff;
      busy_in        = busy_ff;
      live_in        = live_ff;
      start_in       = start_ff;
      unit_we        = 1'b0;
      rsp_matched_in = rsp_matched_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         unique case (s1_op_ff)
            gwm_pkg::OP_APPEND: begin
               busy_in = 1'b0;
               open_in = !s1_last_ff;
               if (!open_ff) begin
                  start_in = gwm_pkg::VEC_W'(1);
               end
               if (wr_pos < gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX)) begin
                  unit_we           = 1'b1;
                  len_in            = wr_next;
                  start_in[wr_next] = (open_ff ? start_ff[wr_pos] : 1'b1) && sym_star;
               end
            end
            gwm_pkg::OP_EMPTY: begin
               busy_in  = 1'b0;
               open_in  = 1'b0;
               len_in   = '0;
               start_in = gwm_pkg::VEC_W'(1);
            end
            gwm_pkg::OP_SUBJECT: begin
               open_in = 1'b0;
               live_in = closed_vec;
               busy_in = !s1_last_ff;
               if (s1_last_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = closed_vec[len_ff];
               end
            end
            gwm_pkg::OP_END: begin
               open_in        = 1'b0;
               busy_in        = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = start_ff[len_ff];
            end
            default: begin
               open_in = open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (unit_we) begin
         units_ff[unit_idx] <= s1_sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         open_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         live_ff      <= '0;
         start_ff     <= gwm_pkg::VEC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         open_ff      <= open_in;
         busy_ff      <= busy_in;
         live_ff      <= live_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX))
      else $error("pattern length beyond capacity");

   a_start_root: assert property (@(posedge clock) disable iff (reset)
      start_ff[0])
      else $error("empty prefix not live for empty subject");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_has_result))
      else $error("input stalled without a blocked result");

   a_empty_pattern: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_op_ff == gwm_pkg::OP_EMPTY)) |=> (len_ff == '0) && !open_ff && !busy_ff)
      else $error("empty pattern not applied");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_has_result && !(rsp_valid_ff && rsp_stall)) |=> !rsp_valid_ff)
      else $error("result produced by a beat that gives none");

endmodule
`default_nettype wire
